// ===== hdl/qtls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qtls_pkg;
  localparam int StripRowsDef   = 240;
  localparam int MbCountDef     = 16;
  localparam int PixelWidthDef  = 16;
  localparam int CoefW          = 7;
  localparam int RunW           = 9;
  localparam int SegXW          = 10;
  localparam int WordW          = 16;
  localparam int PixXW          = 11;
  localparam int PixYW          = 8;
  localparam int ColW           = 16;

  typedef struct packed {
    logic       load;      // latch a coefficient into the datapath
    logic       dc;        // coefficient is a dc value
    logic [3:0] slot;      // buffer slot 0..8
    logic       do_lift;   // run the lifting step on the full buffer
    logic [1:0] level;     // tree level of the lift
    logic       store_kids;// keep children of an inner node
    logic       ascend_ld; // load next sibling predictors
    logic [1:0] asc_lv;    // level receiving predictors
    logic [1:0] asc_k;     // sibling number 1..3
    logic       emit;      // leaf colours valid this cycle
  } qtls_cmd_t;

  typedef struct packed {
    logic [CoefW-1:0] coef;
  } qtls_coef_t;
endpackage
`default_nettype wire

// ===== hdl/qtls_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface qtls_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_segment;
  logic [qtls_pkg::SegXW-1:0]    segment_x;
  logic [qtls_pkg::WordW-1:0]    coded_word;
  modport source (output valid, start_segment, segment_x, coded_word, input ready);
  modport sink   (input valid, start_segment, segment_x, coded_word, output ready);
endinterface

interface qtls_out_if;
  logic                          valid;
  logic                          ready;
  logic [qtls_pkg::PixXW-1:0]    pixel_x;
  logic [qtls_pkg::PixYW-1:0]    pixel_y;
  logic [qtls_pkg::ColW-1:0]     colour_top_left;
  logic [qtls_pkg::ColW-1:0]     colour_top_right;
  logic [qtls_pkg::ColW-1:0]     colour_bottom_left;
  logic [qtls_pkg::ColW-1:0]     colour_bottom_right;
  logic                          last_of_segment;
  modport source (output valid, pixel_x, pixel_y, colour_top_left, colour_top_right,
                  colour_bottom_left, colour_bottom_right, last_of_segment, input ready);
  modport sink   (input valid, pixel_x, pixel_y, colour_top_left, colour_top_right,
                  colour_bottom_left, colour_bottom_right, last_of_segment, output ready);
endinterface
`default_nettype wire

// ===== hdl/qtls_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qtls_datapath #(
  parameter int PixelWidth = qtls_pkg::PixelWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire qtls_pkg::qtls_cmd_t         cmd_i,
  input  wire logic [qtls_pkg::CoefW-1:0]  coef_i,
  output logic [qtls_pkg::ColW-1:0]        col_o [4]
);
  localparam int W = PixelWidth;
  typedef logic signed [W-1:0] pix_t;

  pix_t buf_q  [9];
  pix_t pred_q [12];
  pix_t kids_q [27];
  pix_t q_q    [3][4];

  pix_t q_c [3][4];
  pix_t coef_ext;

  function automatic logic [4:0] clamp5(input pix_t v);
    if (v < 0) return 5'd0;
    else if (v > pix_t'(31)) return 5'd31;
    else return v[4:0];
  endfunction

  assign coef_ext = pix_t'(signed'(coef_i));

  // three lifting steps side by side, one per colour
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pix_t p, b0, b1, b2, c1, c2, c3;
      p  = pred_q[int'(cmd_i.level) * 3 + c];
      b0 = buf_q[c*3];
      b1 = buf_q[c*3+1];
      b2 = buf_q[c*3+2];
      c1 = b2 - (b0 >>> 1);
      c2 = c1 + b0;
      c3 = p - (b1 >>> 1);
      q_c[c][0] = c3 - (c1 >>> 1);
      q_c[c][1] = q_c[c][0] + c1;
      q_c[c][2] = c3 - (c2 >>> 1) + b1;
      q_c[c][3] = q_c[c][2] + c2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      buf_q[cmd_i.slot] <= coef_ext;
      if (cmd_i.dc) pred_q[cmd_i.slot] <= coef_ext;
    end
    if (cmd_i.do_lift) begin
      q_q <= q_c;
      if (cmd_i.store_kids) begin
        for (int c = 0; c < 3; c++) begin
          for (int k = 0; k < 3; k++)
            kids_q[(int'(cmd_i.level)*3 + k)*3 + c] <= q_c[c][k];
          pred_q[int'(cmd_i.level)*3 + c]     <= q_c[c][3];
          pred_q[(int'(cmd_i.level)+1)*3 + c] <= q_c[c][0];
        end
      end
    end
    if (cmd_i.ascend_ld) begin
      for (int c = 0; c < 3; c++)
        pred_q[int'(cmd_i.asc_lv)*3 + c] <= (cmd_i.asc_k < 2'd3)
          ? kids_q[((int'(cmd_i.asc_lv)-1)*3 + int'(cmd_i.asc_k))*3 + c]
          : pred_q[(int'(cmd_i.asc_lv)-1)*3 + c];
    end
  end

  // red in 15..11, green in 10..6, blue in 4..0
  always_comb begin
    for (int k = 0; k < 4; k++)
      col_o[k] = {clamp5(q_q[0][k]), clamp5(q_q[1][k]), 1'b0, clamp5(q_q[2][k])};
  end
  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
`default_nettype wire

// ===== hdl/qtls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qtls_ctrl #(
  parameter int StripRows = qtls_pkg::StripRowsDef,
  parameter int MbCount   = qtls_pkg::MbCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          start_i,
  input  wire logic [qtls_pkg::SegXW-1:0]    segx_i,
  input  wire logic [qtls_pkg::WordW-1:0]    word_i,
  output qtls_pkg::qtls_cmd_t                cmd_o,
  output logic [qtls_pkg::CoefW-1:0]         coef_o,
  output logic                               emit_o,
  output logic [qtls_pkg::PixXW-1:0]         px_o,
  output logic [qtls_pkg::PixYW-1:0]         py_o,
  output logic                               bottom_ok_o,
  output logic                               last_o,
  input  wire logic                          res_busy_i
);
  localparam int MbW   = $clog2(MbCount + 1);
  localparam int YW    = $clog2(16 * MbCount + 1);
  localparam int LimV  = (16 * MbCount > StripRows) ? StripRows : 16 * MbCount;
  localparam int YLast = (LimV - 1) & ~1;

  typedef enum logic [2:0] {S_IDLE, S_HELD, S_RUN, S_LIFT, S_LEAF, S_ASC} state_e;
  state_e state_q;

  logic [qtls_pkg::RunW-1:0]  run_q;
  logic [qtls_pkg::CoefW-1:0] held_q, cur_q;
  logic [qtls_pkg::SegXW-1:0] segx_q;
  logic [MbW-1:0]             mb_q;
  logic                       dc_q, done_q;
  logic [3:0]                 fill_q;
  logic [1:0]                 lvl_q, asc_lv_q;
  logic [1:0]                 cp_q [3];

  logic [YW+1:0] y_c;
  logic [4:0]    x_c;
  always_comb begin
    x_c = 5'({cp_q[0][0], 3'b0}) + 5'({cp_q[1][0], 2'b0}) + 5'({cp_q[2][0], 1'b0});
    y_c = (YW+2)'(16 * int'(mb_q)) + (YW+2)'({cp_q[0][1], 3'b0})
        + (YW+2)'({cp_q[1][1], 2'b0}) + (YW+2)'({cp_q[2][1], 1'b0});
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; run_q <= '0; held_q <= '0; cur_q <= '0; segx_q <= '0;
      mb_q <= '0; dc_q <= 1'b1; done_q <= 1'b0; fill_q <= '0; lvl_q <= '0;
      asc_lv_q <= '0; cp_q <= '{default: '0};
      cmd_o <= '0; coef_o <= '0; emit_o <= 1'b0; px_o <= '0; py_o <= '0;
      bottom_ok_o <= 1'b0; last_o <= 1'b0;
    end else begin
      cmd_o  <= '0;
      emit_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            segx_q <= segx_i;
            held_q <= word_i[6:0];
            run_q  <= word_i[15:7];
            cur_q  <= held_q;
            if (start_i) begin
              mb_q <= '0; dc_q <= 1'b1; done_q <= 1'b0; fill_q <= '0;
              lvl_q <= '0; cp_q <= '{default: '0};
              state_q <= S_RUN;
            end else begin
              state_q <= S_HELD;
            end
          end
        end
        S_HELD, S_RUN: begin
          // one coefficient delivered per cycle, dropped once every macroblock is done
          logic deliver;
          logic [qtls_pkg::CoefW-1:0] cf;
          deliver = (state_q == S_HELD) || (run_q != '0);
          cf = (state_q == S_HELD) ? cur_q : '0;
          if (state_q == S_RUN && run_q != '0) run_q <= run_q - 1'b1;
          if (!deliver) begin
            state_q <= S_IDLE;
          end else if (done_q) begin
            state_q <= S_RUN;
          end else begin
            cmd_o.load <= 1'b1; cmd_o.dc <= dc_q; cmd_o.slot <= fill_q;
            coef_o <= cf;
            state_q <= S_RUN;
            if (dc_q) begin
              if (fill_q == 4'd2) begin
                dc_q <= 1'b0; fill_q <= '0; lvl_q <= '0; cp_q <= '{default: '0};
              end else fill_q <= fill_q + 1'b1;
            end else if (fill_q == 4'd8) begin
              fill_q <= '0; state_q <= S_LIFT;
            end else fill_q <= fill_q + 1'b1;
          end
        end
        S_LIFT: begin
          cmd_o.do_lift <= 1'b1; cmd_o.level <= lvl_q;
          if (lvl_q == 2'd3) begin
            state_q <= S_LEAF;
          end else begin
            cmd_o.store_kids <= 1'b1;
            cp_q[lvl_q] <= '0;
            lvl_q <= lvl_q + 1'b1;
            state_q <= S_RUN;
          end
        end
        S_LEAF: begin
          // wait for the result slot, then emit if the row lies inside the strip
          if (!res_busy_i) begin
            if (y_c < (YW+2)'(StripRows)) begin
              emit_o <= 1'b1;
              px_o <= qtls_pkg::PixXW'(segx_q) + qtls_pkg::PixXW'(x_c);
              py_o <= y_c[qtls_pkg::PixYW-1:0];
              bottom_ok_o <= (y_c + 1'b1) < (YW+2)'(StripRows);
              last_o <= (x_c == 5'd14) && (y_c == (YW+2)'(YLast));
            end
            asc_lv_q <= 2'd3;
            state_q <= S_ASC;
          end
        end
        S_ASC: begin
          if (asc_lv_q == 2'd0) begin
            mb_q <= mb_q + 1'b1; dc_q <= 1'b1; fill_q <= '0; lvl_q <= '0;
            if (int'(mb_q) + 1 >= MbCount) done_q <= 1'b1;
            state_q <= S_RUN;
          end else if (cp_q[asc_lv_q - 1'b1] < 2'd3) begin
            cp_q[asc_lv_q - 1'b1] <= cp_q[asc_lv_q - 1'b1] + 1'b1;
            cmd_o.ascend_ld <= 1'b1; cmd_o.asc_lv <= asc_lv_q;
            cmd_o.asc_k <= cp_q[asc_lv_q - 1'b1] + 1'b1;
            lvl_q <= asc_lv_q; fill_q <= '0;
            state_q <= S_RUN;
          end else begin
            asc_lv_q <= asc_lv_q - 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/quadtree_lifting_strip_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// in_ch   | in  | start_segment, segment_x, coded_word
// out_ch  | out | pixel_x, pixel_y, four colours, last_of_segment
// one coefficient per cycle, held while the fsm lifts, emits or ascends: the
// held one, then the zero run (the run alone with start); a new word is taken
// only once its run is through, with inner-node lifts, leaf lift, emit and ascent
// between; the controller fsm sets the rate; a leaf waits while the output word is unsent
// reset clears run, held coefficient, tree pointers; stores need no clearing
module quadtree_lifting_strip_decoder #(
  parameter int StripRows  = qtls_pkg::StripRowsDef,
  parameter int MbCount    = qtls_pkg::MbCountDef,
  parameter int PixelWidth = qtls_pkg::PixelWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qtls_in_if.sink   in_ch,
  qtls_out_if.source out_ch
);
  qtls_pkg::qtls_cmd_t cmd;
  logic [qtls_pkg::CoefW-1:0] coef;
  logic emit, bot_ok, last;
  logic [qtls_pkg::PixXW-1:0] px;
  logic [qtls_pkg::PixYW-1:0] py;
  logic [qtls_pkg::ColW-1:0] col [4];
  logic out_v_q;

  qtls_ctrl #(.StripRows(StripRows), .MbCount(MbCount)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .start_i(in_ch.start_segment), .segx_i(in_ch.segment_x), .word_i(in_ch.coded_word),
    .cmd_o(cmd), .coef_o(coef), .emit_o(emit), .px_o(px), .py_o(py),
    .bottom_ok_o(bot_ok), .last_o(last), .res_busy_i(out_v_q));

  qtls_datapath #(.PixelWidth(PixelWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .coef_i(coef), .col_o(col));

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit) begin
      out_v_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ch.pixel_x <= px;
      out_ch.pixel_y <= py;
      out_ch.colour_top_left <= col[0];
      out_ch.colour_top_right <= col[1];
      out_ch.colour_bottom_left <= bot_ok ? col[2] : '0;
      out_ch.colour_bottom_right <= bot_ok ? col[3] : '0;
      out_ch.last_of_segment <= last;
    end
  end
  assign out_ch.valid = out_v_q;
endmodule
`default_nettype wire
